// ===== rtl/tbpd_pkg.sv =====
// ----------------------------------------------------------------------------
// tbpd_pkg
// shared widths, constants and register codes of the token bucket pacing unit
// ----------------------------------------------------------------------------
`default_nettype none

package tbpd_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned SEG_W         = 17;
  localparam int unsigned DELAY_W       = 32;
  localparam int unsigned RATE_W        = 20;
  localparam int unsigned KIB_SHIFT     = 10;
  localparam int unsigned UPB_W         = 20;
  localparam int unsigned MUL_W         = RATE_W + UPB_W;

  localparam logic [UPB_W-1:0] UNITS_PER_BYTE = 20'd1000000;

  localparam int unsigned APB_DW      = 32;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned REG_IDX_LSB = 2;

  typedef enum logic [0:0] {
    REG_LINK_RATE = 1'b0
  } reg_idx_e;

endpackage

`default_nettype wire

// ===== rtl/tbpd_req_if.sv =====
// ----------------------------------------------------------------------------
// tbpd_req_if
// segment request channel: timestamp and byte count
// ----------------------------------------------------------------------------
`default_nettype none

interface tbpd_req_if;
  logic                          valid;
  logic                          ready;
  logic [tbpd_pkg::TIME_W-1:0]   now_us;
  logic [tbpd_pkg::SEG_W-1:0]    seg_bytes;

  modport source (output valid, output now_us, output seg_bytes, input ready);
  modport sink   (input valid, input now_us, input seg_bytes, output ready);
endinterface

`default_nettype wire

// ===== rtl/tbpd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tbpd_rsp_if
// pacing delay result channel
// ----------------------------------------------------------------------------
`default_nettype none

interface tbpd_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [tbpd_pkg::DELAY_W-1:0] delay_us;

  modport source (output valid, output delay_us, input ready);
  modport sink   (input valid, input delay_us, output ready);
endinterface

`default_nettype wire

// ===== rtl/tbpd_addsub.sv =====
// ----------------------------------------------------------------------------
// tbpd_addsub
// shared wide adder / subtractor used by the sequencer steps compare to divide
// ----------------------------------------------------------------------------
`default_nettype none

module tbpd_addsub #(
  parameter int unsigned W = 66
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] sum_o
);

  logic [W-1:0] b_op;

  assign b_op  = sub_i ? ~b_i : b_i;
  assign sum_o = a_i + b_op + W'(sub_i);

endmodule

`default_nettype wire

// ===== rtl/token_bucket_pacing_delay_unit.sv =====
// ----------------------------------------------------------------------------
// token_bucket_pacing_delay_unit
// shared-link token bucket that answers a pacing delay for every segment
// ----------------------------------------------------------------------------
// req_i carries one segment request (now_us, seg_bytes); rsp_o returns one
// delay_us for each request, in order. the link rate in KiB/s is written
// over the APB port at address 0, and the user must write it only while the
// unit is idle; the block leaves this to the user and checks nothing. zero
// turns pacing off and the answer is 0 with the bucket untouched.
// a paced request runs through a shared multiplier and one shared adder
// under a small sequencer: cap and cost products, bucket compare, elapsed x
// rate shift-add over the rate bits, refill check and add, segment subtract,
// deficit negate and range check, restoring divide, result load.
// a full bucket skips the refill steps; no deficit or a saturated delay
// skips the later steps. a bypassed request goes straight to the result load.
// req_i.ready is high only while idle, so one request is in work at a time;
// the finished delay sits in an output register, and a new request is taken
// while it waits. when rsp_o stalls, the next result waits in the
// sequencer until the output register frees up.
// reset empties the bucket, clears the rate and the started flag, and drops
// any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module token_bucket_pacing_delay_unit #(
  parameter int unsigned TIME_BITS = tbpd_pkg::TIME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tbpd_req_if.sink                        req_i,
  tbpd_rsp_if.source                      rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tbpd_pkg::PADDR_W-1:0]    paddr,
  input  logic [tbpd_pkg::APB_DW-1:0]     pwdata,
  output logic [tbpd_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);

  localparam int unsigned RateW = tbpd_pkg::RATE_W;
  localparam int unsigned AccW  = TIME_BITS + RateW;
  localparam int unsigned ProdW = AccW + tbpd_pkg::KIB_SHIFT;
  localparam int unsigned AW    = ((ProdW > 65) ? ProdW : 65) + 1;
  localparam int unsigned CapW  = tbpd_pkg::MUL_W + tbpd_pkg::KIB_SHIFT;
  localparam int unsigned CostW = tbpd_pkg::SEG_W + tbpd_pkg::UPB_W;
  localparam int unsigned RemW  = 64 - tbpd_pkg::KIB_SHIFT;
  localparam int unsigned DW    = tbpd_pkg::DELAY_W;
  localparam int unsigned DvW   = RateW + DW - 1;
  localparam int unsigned CntW  = 5;
  localparam logic [CntW-1:0] MulLast = CntW'(RateW - 1);
  localparam logic [CntW-1:0] DivLast = CntW'(DW - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CAP, S_COST, S_CMP, S_MUL, S_CHK, S_ADD,
    S_SUB, S_NEG, S_SAT, S_DIV, S_OUT
  } state_e;

  state_e                  state_q;
  logic [RateW-1:0]        rate_q;
  logic [TIME_BITS-1:0]    last_q;
  logic                    started_q;
  logic signed [63:0]      token_q;
  logic [tbpd_pkg::SEG_W-1:0] seg_q;
  logic [CapW-1:0]         cap_q;
  logic [CostW-1:0]        cost_q;
  logic [63:0]             gap_q;
  logic [AccW-1:0]         mcand_q;
  logic [RateW-1:0]        mplier_q;
  logic [AccW-1:0]         acc_q;
  logic [RemW-1:0]         rem_q;
  logic [DvW-1:0]          dv_q;
  logic [DW-1:0]           quo_q;
  logic [DW-1:0]           delay_q;
  logic                    out_valid_q;
  logic [CntW-1:0]         cnt_q;

  logic [63:0]             now_ext;
  logic [TIME_BITS-1:0]    now_t;
  logic [TIME_BITS-1:0]    elapsed;
  logic                    req_fire;
  logic                    cfg_wr;
  logic                    out_free;
  logic [AW-1:0]           alu_a;
  logic [AW-1:0]           alu_b;
  logic                    alu_sub;
  logic [AW-1:0]           alu_sum;
  logic                    alu_neg;
  logic [RateW-1:0]        mul_a;
  logic [tbpd_pkg::MUL_W-1:0] mul_p;
  logic [ProdW-1:0]        prod;
  logic [63:0]             tok_sub;

  assign now_ext  = 64'(req_i.now_us);
  assign now_t    = now_ext[TIME_BITS-1:0];
  assign elapsed  = now_t - last_q;
  assign req_fire = req_i.valid && req_i.ready;
  assign cfg_wr   = psel && penable && pwrite && pready
                    && (paddr[tbpd_pkg::PADDR_W-1:tbpd_pkg::REG_IDX_LSB]
                        == tbpd_pkg::REG_LINK_RATE);
  assign out_free = !out_valid_q || rsp_o.ready;

  assign req_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.delay_us = delay_q;
  assign pready         = 1'b1;
  assign prdata         = tbpd_pkg::APB_DW'(rate_q);

  // shared multiplier: bucket cap, then segment cost
  assign mul_a = (state_q == S_CAP) ? rate_q : RateW'(seg_q);
  assign mul_p = tbpd_pkg::MUL_W'(mul_a) * tbpd_pkg::MUL_W'(tbpd_pkg::UNITS_PER_BYTE);
  assign prod  = {acc_q, tbpd_pkg::KIB_SHIFT'(0)};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_CMP: begin
        alu_a   = AW'(cap_q);
        alu_b   = AW'(token_q);
        alu_sub = 1'b1;
      end
      S_MUL: begin
        alu_a = AW'(acc_q);
        alu_b = mplier_q[0] ? AW'(mcand_q) : '0;
      end
      S_CHK: begin
        alu_a   = AW'(gap_q);
        alu_b   = AW'(prod);
        alu_sub = 1'b1;
      end
      S_ADD: begin
        alu_a = AW'(token_q);
        alu_b = AW'(prod);
      end
      S_SUB: begin
        alu_a   = AW'(token_q);
        alu_b   = AW'(cost_q);
        alu_sub = 1'b1;
      end
      S_NEG: begin
        alu_b   = AW'(token_q);
        alu_sub = 1'b1;
      end
      S_SAT: begin
        alu_a   = AW'(rem_q);
        alu_b   = AW'({rate_q, DW'(0)});
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = AW'(rem_q);
        alu_b   = AW'(dv_q);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  tbpd_addsub #(
    .W (AW)
  ) u_addsub (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  assign alu_neg = alu_sum[AW-1];

  // saturate at the least signed value when the segment cost underflows
  assign tok_sub = (alu_sum[64] != alu_sum[63]) ? {1'b1, 63'(0)} : alu_sum[63:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rate_q      <= '0;
      last_q      <= '0;
      started_q   <= 1'b0;
      token_q     <= '0;
      seg_q       <= '0;
      cap_q       <= '0;
      cost_q      <= '0;
      gap_q       <= '0;
      mcand_q     <= '0;
      mplier_q    <= '0;
      acc_q       <= '0;
      rem_q       <= '0;
      dv_q        <= '0;
      quo_q       <= '0;
      delay_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_wr) begin
        rate_q <= pwdata[RateW-1:0];
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            seg_q <= req_i.seg_bytes;
            quo_q <= '0;
            if (rate_q == '0) begin
              state_q <= S_OUT;
            end else begin
              mcand_q   <= started_q ? AccW'(elapsed) : '0;
              mplier_q  <= rate_q;
              acc_q     <= '0;
              cnt_q     <= '0;
              last_q    <= now_t;
              started_q <= 1'b1;
              if (!started_q) begin
                token_q <= '0;
              end
              state_q <= S_CAP;
            end
          end
        end
        S_CAP: begin
          cap_q   <= {mul_p, tbpd_pkg::KIB_SHIFT'(0)};
          state_q <= S_COST;
        end
        S_COST: begin
          cost_q  <= mul_p[CostW-1:0];
          state_q <= S_CMP;
        end
        S_CMP: begin
          gap_q <= alu_sum[63:0];
          if (alu_neg || alu_sum == '0) begin
            token_q <= 64'(cap_q);
            state_q <= S_SUB;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          acc_q    <= alu_sum[AccW-1:0];
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          cnt_q    <= cnt_q + 1'b1;
          if (cnt_q == MulLast) begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (alu_neg) begin
            token_q <= 64'(cap_q);
            state_q <= S_SUB;
          end else begin
            state_q <= S_ADD;
          end
        end
        S_ADD: begin
          token_q <= alu_sum[63:0];
          state_q <= S_SUB;
        end
        S_SUB: begin
          token_q <= tok_sub;
          if (tok_sub[63]) begin
            state_q <= S_NEG;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_NEG: begin
          rem_q   <= alu_sum[63:tbpd_pkg::KIB_SHIFT];
          state_q <= S_SAT;
        end
        S_SAT: begin
          if (!alu_neg) begin
            quo_q   <= '1;
            state_q <= S_OUT;
          end else begin
            dv_q    <= {rate_q, (DW-1)'(0)};
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (!alu_neg) begin
            rem_q <= alu_sum[RemW-1:0];
          end
          quo_q <= {quo_q[DW-2:0], !alu_neg};
          dv_q  <= dv_q >> 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivLast) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            delay_q <= quo_q;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_i.ready)
    else $error("request taken while a request is still in work");

  a_bucket_capped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUB) |-> ($signed(token_q) <= $signed(64'(cap_q))))
    else $error("bucket above one second of credit after refill");

  a_div_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < RemW'({dv_q, 1'b0})))
    else $error("divide remainder out of range");

  a_result_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result loaded outside the result step");

endmodule

`default_nettype wire
